>>> sv/mis_pkg.sv
// shared widths, constants and the front-to-back word type of the mass index stream
package mis_pkg;

  localparam int PriceW       = 32;
  localparam int AlphaW       = 17;
  localparam int SpW          = 6;
  localparam int RangeW       = PriceW + 1;
  localparam int EmaW         = 49;
  localparam int RatioW       = 24;
  localparam int OutW         = 29;
  localparam int FracW        = 16;
  localparam int CfgDataW     = 32;
  localparam int CfgAddrW     = 3;
  localparam int QueueDepth   = 2;
  localparam int MaxWindowDef = 32;

  localparam logic [AlphaW-1:0] AlphaMin = 17'd1;
  localparam logic [AlphaW-1:0] AlphaOne = 17'd65536;
  localparam logic [AlphaW-1:0] AlphaDef = 17'd13107;
  localparam logic [SpW-1:0]    SpDef    = 6'd25;

  localparam logic signed [RatioW-1:0] RatioOne = 24'sd65536;
  localparam logic signed [RatioW-1:0] RatioMax = 24'sh7FFFFF;
  localparam logic signed [RatioW-1:0] RatioMin = 24'sh800000;
  localparam logic [RatioW-1:0]        QuoNegLimit = 24'h800000;

  localparam logic signed [OutW-1:0] SumMax = 29'sh0FFFFFFF;
  localparam logic signed [OutW-1:0] SumMin = 29'sh10000000;

  typedef struct packed {
    logic                   restart;
    logic signed [EmaW-1:0] first_ema;
    logic signed [EmaW-1:0] second_ema;
  } ema_pair_t;

endpackage

>>> sv/mass_index_stream_core.sv
// top level of the mass index stream: config registers, front end, queue, back end
//
// Input channel in_valid/in_ready carries one price bar per word: in_bar_high,
// in_bar_low (unsigned Q16.16) and in_start_of_series. Output channel
// out_valid/out_ready carries one word per bar: out_mass_value, signed Q12.16,
// the sum of the latest min(window length, bars in series) ema ratios.
// The front end runs the two ema updates (a seed bar seeds both from its range,
// others pass two multiply and two add states) and writes the ema pair into a
// two-entry queue, so it keeps taking bars while the back end works. Per bar
// the back end runs a 25-step shift-subtract divider for the ratio, one ring
// write, then one ring memory read per summed ratio, the summed ratios being
// the window. That back end loop sets the sustained rate.
// Register 0 at address 0 is ema_alpha (Q1.16, 17 bits), register 1 at
// address 4 is the window length (6 bits); write them only while the block is idle.
// Reset loads the default register values and leaves no open series; the
// first bar after reset always starts a series. When out_ready stays low the
// finished word holds in the output register, the back end waits with its
// next result, and once the queue fills in_ready drops.
module mass_index_stream_core #(
  parameter int MAX_WINDOW = mis_pkg::MaxWindowDef
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mis_pkg::PriceW-1:0]        in_bar_high,
  input  logic [mis_pkg::PriceW-1:0]        in_bar_low,
  input  logic                              in_start_of_series,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mis_pkg::OutW-1:0]   out_mass_value,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mis_pkg::CfgAddrW-1:0]      paddr,
  input  logic [mis_pkg::CfgDataW-1:0]      pwdata,
  output logic [mis_pkg::CfgDataW-1:0]      prdata,
  output logic                              pready
);

  localparam logic RegEmaAlpha  = 1'b0;
  localparam logic RegWindowLen = 1'b1;

  logic [mis_pkg::AlphaW-1:0]  alpha_r;
  logic [mis_pkg::SpW-1:0]     window_len_r;
  logic [mis_pkg::AlphaW-1:0]  alpha_eff;
  logic                        cfg_wr;
  logic                        reg_sel;

  logic                        fq_valid;
  logic                        fq_ready;
  mis_pkg::ema_pair_t          fq_data;
  logic                        qb_valid;
  logic                        qb_ready;
  mis_pkg::ema_pair_t          qb_data;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_sel)
      RegEmaAlpha:  prdata = mis_pkg::CfgDataW'(alpha_r);
      RegWindowLen: prdata = mis_pkg::CfgDataW'(window_len_r);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r      <= mis_pkg::AlphaDef;
      window_len_r <= mis_pkg::SpDef;
    end else if (cfg_wr) begin
      if (reg_sel == RegEmaAlpha) begin
        alpha_r <= pwdata[mis_pkg::AlphaW-1:0];
      end else begin
        window_len_r <= pwdata[mis_pkg::SpW-1:0];
      end
    end
  end

  // zero acts as the smallest step, anything above 1.0 as 1.0
  assign alpha_eff = (alpha_r == '0) ? mis_pkg::AlphaMin :
                     (alpha_r > mis_pkg::AlphaOne) ? mis_pkg::AlphaOne : alpha_r;

  mis_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_bar_high        (in_bar_high),
    .in_bar_low         (in_bar_low),
    .in_start_of_series (in_start_of_series),
    .alpha              (alpha_eff),
    .q_valid            (fq_valid),
    .q_ready            (fq_ready),
    .q_data             (fq_data)
  );

  mis_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  mis_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (qb_valid),
    .q_ready        (qb_ready),
    .q_data         (qb_data),
    .window_len     (window_len_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_mass_value (out_mass_value)
  );

endmodule

>>> sv/mis_front.sv
// front end: takes bars, runs both ema updates and hands the ema pair on
module mis_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mis_pkg::PriceW-1:0]    in_bar_high,
  input  logic [mis_pkg::PriceW-1:0]    in_bar_low,
  input  logic                          in_start_of_series,
  input  logic [mis_pkg::AlphaW-1:0]    alpha,
  output logic                          q_valid,
  input  logic                          q_ready,
  output mis_pkg::ema_pair_t            q_data
);

  localparam int DiffW = mis_pkg::EmaW + 1;
  localparam int ProdW = mis_pkg::AlphaW + 1 + DiffW;
  localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(32768);

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL1,
    F_ADD1,
    F_MUL2,
    F_ADD2,
    F_PUSH
  } fstate_t;

  fstate_t                               state_r;
  logic                                  open_r;
  logic                                  restart_r;
  logic signed [mis_pkg::RangeW-1:0]     range_r;
  logic signed [mis_pkg::EmaW-1:0]       e1_r;
  logic signed [mis_pkg::EmaW-1:0]       e2_r;
  logic signed [ProdW-1:0]               prod_r;

  logic signed [mis_pkg::RangeW-1:0]     range_in;
  logic signed [DiffW-1:0]               diff_sel;
  logic signed [ProdW-1:0]               prod_nxt;
  logic signed [ProdW-1:0]               step_full;
  logic signed [mis_pkg::EmaW-1:0]       e_add;

  assign range_in  = $signed({1'b0, in_bar_high}) - $signed({1'b0, in_bar_low});
  assign diff_sel  = (state_r == F_MUL1) ? (DiffW'(range_r) - DiffW'(e1_r))
                                         : (DiffW'(e1_r) - DiffW'(e2_r));
  // e' = e + round(alpha * (x - e) / 2^16), ties toward +inf
  assign prod_nxt  = $signed({1'b0, alpha}) * diff_sel;
  assign step_full = (prod_r + RoundHalf) >>> mis_pkg::FracW;
  assign e_add     = mis_pkg::EmaW'(step_full);

  assign in_ready = (state_r == F_IDLE);
  assign q_valid  = (state_r == F_PUSH);
  assign q_data   = '{restart: restart_r, first_ema: e1_r, second_ema: e2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      open_r    <= 1'b0;
      restart_r <= 1'b0;
      e1_r      <= '0;
      e2_r      <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            range_r   <= range_in;
            restart_r <= in_start_of_series || !open_r;
            if (in_start_of_series || !open_r) begin
              // new series: both emas seed from this bar
              e1_r    <= mis_pkg::EmaW'(range_in);
              e2_r    <= mis_pkg::EmaW'(range_in);
              open_r  <= 1'b1;
              state_r <= F_PUSH;
            end else begin
              state_r <= F_MUL1;
            end
          end
        end
        F_MUL1: begin
          prod_r  <= prod_nxt;
          state_r <= F_ADD1;
        end
        F_ADD1: begin
          e1_r    <= e1_r + e_add;
          state_r <= F_MUL2;
        end
        F_MUL2: begin
          prod_r  <= prod_nxt;
          state_r <= F_ADD2;
        end
        F_ADD2: begin
          e2_r    <= e2_r + e_add;
          state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (q_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: begin
          state_r <= F_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/mis_queue.sv
// short fifo of ema pairs between the front and back ends
module mis_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  mis_pkg::ema_pair_t   push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output mis_pkg::ema_pair_t   pop_data
);

  localparam int PtrW = $clog2(mis_pkg::QueueDepth);
  localparam int CntW = $clog2(mis_pkg::QueueDepth + 1);

  mis_pkg::ema_pair_t  slots_r [mis_pkg::QueueDepth];
  logic [PtrW-1:0]     wr_ptr_r;
  logic [PtrW-1:0]     rd_ptr_r;
  logic [CntW-1:0]     count_r;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count_r != CntW'(mis_pkg::QueueDepth));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(mis_pkg::QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(mis_pkg::QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> sv/mis_back.sv
// back end: ratio divider, ratio ring and window sum with the output register
module mis_back #(
  parameter int MAX_WINDOW = mis_pkg::MaxWindowDef
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  mis_pkg::ema_pair_t                q_data,
  input  logic [mis_pkg::SpW-1:0]           window_len,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mis_pkg::OutW-1:0]   out_mass_value
);

  localparam int IdxW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CntW  = $clog2(MAX_WINDOW + 1);
  localparam int SpXW  = (CntW > mis_pkg::SpW) ? CntW : mis_pkg::SpW;
  localparam int AccW  = mis_pkg::RatioW + CntW;
  localparam int SatW  = (AccW > mis_pkg::OutW) ? AccW : mis_pkg::OutW;
  localparam int QuoW  = mis_pkg::RatioW;
  localparam int NumW  = mis_pkg::EmaW + mis_pkg::FracW;
  localparam int DshW  = mis_pkg::EmaW + QuoW;
  localparam int StepW = $clog2(QuoW + 1);

  typedef enum logic [2:0] {
    B_IDLE,
    B_PREP,
    B_DIV,
    B_WRITE,
    B_SUM,
    B_DONE
  } bstate_t;

  bstate_t                               state_r;
  mis_pkg::ema_pair_t                    pair_r;
  logic [NumW-1:0]                       rem_r;
  logic [DshW-1:0]                       dsh_r;
  logic [QuoW-1:0]                       quo_r;
  logic [StepW-1:0]                      step_r;
  logic                                  ovf_r;
  logic                                  neg_r;
  logic                                  dzero_r;
  logic [IdxW-1:0]                       slot_r;
  logic [CntW-1:0]                       seen_r;
  logic [IdxW-1:0]                       rd_idx_r;
  logic [CntW-1:0]                       left_r;
  logic                                  rd_vld_r;
  logic signed [mis_pkg::RatioW-1:0]     rd_data_r;
  logic signed [AccW-1:0]                acc_r;
  logic                                  out_valid_r;
  logic signed [mis_pkg::OutW-1:0]       out_value_r;

  logic signed [mis_pkg::RatioW-1:0]     ring_mem [MAX_WINDOW];

  logic [mis_pkg::EmaW-1:0]              abs_num;
  logic [mis_pkg::EmaW-1:0]              abs_den;
  logic                                  ge;
  logic signed [mis_pkg::RatioW-1:0]     quo_s;
  logic signed [mis_pkg::RatioW-1:0]     ratio;
  logic [CntW-1:0]                       seen_nxt;
  logic [SpXW-1:0]                       sp_x;
  logic [SpXW-1:0]                       sp_c;
  logic [CntW-1:0]                       win;
  logic signed [SatW-1:0]                acc_x;
  logic signed [mis_pkg::OutW-1:0]       sum_sat;
  logic                                  out_free;

  assign abs_num = pair_r.first_ema[mis_pkg::EmaW-1] ? (~pair_r.first_ema + 1'b1)
                                                     : pair_r.first_ema;
  assign abs_den = pair_r.second_ema[mis_pkg::EmaW-1] ? (~pair_r.second_ema + 1'b1)
                                                      : pair_r.second_ema;
  assign ge      = (DshW'(rem_r) >= dsh_r);

  // magnitude quotient, then sign and saturation
  assign quo_s = $signed(quo_r);
  always_comb begin
    if (dzero_r) begin
      ratio = mis_pkg::RatioOne;
    end else if (neg_r) begin
      ratio = (ovf_r || (quo_r > mis_pkg::QuoNegLimit)) ? mis_pkg::RatioMin : -quo_s;
    end else begin
      ratio = (ovf_r || quo_r[QuoW-1]) ? mis_pkg::RatioMax : quo_s;
    end
  end

  assign seen_nxt = (seen_r < CntW'(MAX_WINDOW)) ? seen_r + 1'b1 : seen_r;
  assign sp_x     = SpXW'(window_len);
  assign sp_c     = (sp_x == '0) ? SpXW'(1) :
                    (sp_x > SpXW'(MAX_WINDOW)) ? SpXW'(MAX_WINDOW) : sp_x;
  assign win      = (sp_c < SpXW'(seen_nxt)) ? CntW'(sp_c) : seen_nxt;

  assign acc_x    = SatW'(acc_r);
  assign sum_sat  = (acc_x > SatW'(mis_pkg::SumMax)) ? mis_pkg::SumMax :
                    (acc_x < SatW'(mis_pkg::SumMin)) ? mis_pkg::SumMin :
                    mis_pkg::OutW'(acc_x);

  assign out_free       = !out_valid_r || out_ready;
  assign q_ready        = (state_r == B_IDLE);
  assign out_valid      = out_valid_r;
  assign out_mass_value = out_value_r;

  // ratio ring; only slots written in the current series are ever read back
  always_ff @(posedge clk) begin
    if (state_r == B_WRITE) begin
      ring_mem[slot_r] <= ratio;
    end
    rd_data_r <= ring_mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      slot_r      <= '0;
      seen_r      <= '0;
      left_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != B_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            pair_r  <= q_data;
            if (q_data.restart) begin
              slot_r <= '0;
              seen_r <= '0;
            end
            state_r <= B_PREP;
          end
        end
        B_PREP: begin
          rem_r   <= {abs_num, {mis_pkg::FracW{1'b0}}};
          dsh_r   <= {abs_den, {QuoW{1'b0}}};
          neg_r   <= pair_r.first_ema[mis_pkg::EmaW-1] ^ pair_r.second_ema[mis_pkg::EmaW-1];
          dzero_r <= (pair_r.second_ema == '0);
          quo_r   <= '0;
          ovf_r   <= 1'b0;
          step_r  <= StepW'(QuoW);
          state_r <= B_DIV;
        end
        B_DIV: begin
          if (step_r == StepW'(QuoW)) begin
            // first compare only flags a quotient past the ratio range
            ovf_r <= ge;
          end else begin
            if (ge) begin
              rem_r <= rem_r - NumW'(dsh_r);
            end
            quo_r <= {quo_r[QuoW-2:0], ge};
          end
          dsh_r <= dsh_r >> 1;
          if (step_r == '0) begin
            state_r <= B_WRITE;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        B_WRITE: begin
          slot_r   <= (slot_r == IdxW'(MAX_WINDOW - 1)) ? '0 : slot_r + 1'b1;
          seen_r   <= seen_nxt;
          rd_idx_r <= slot_r;
          left_r   <= win;
          acc_r    <= '0;
          rd_vld_r <= 1'b0;
          state_r  <= B_SUM;
        end
        B_SUM: begin
          // walk back from the newest ratio, one read a cycle
          if (left_r != '0) begin
            rd_idx_r <= (rd_idx_r == '0) ? IdxW'(MAX_WINDOW - 1) : rd_idx_r - 1'b1;
            left_r   <= left_r - 1'b1;
            rd_vld_r <= 1'b1;
          end else begin
            rd_vld_r <= 1'b0;
          end
          if (rd_vld_r) begin
            acc_r <= acc_r + AccW'(rd_data_r);
          end
          if ((left_r == '0) && !rd_vld_r) begin
            state_r <= B_DONE;
          end
        end
        B_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_value_r <= sum_sat;
            state_r     <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule
